// ===== rtl/scanner_byte_framer_mailbox_macros.svh =====
// Assertion helpers used by the framer datapath.
`ifndef SCANNER_BYTE_FRAMER_MAILBOX_MACROS_SVH
`define SCANNER_BYTE_FRAMER_MAILBOX_MACROS_SVH

// Same-cycle implication.
`define SBFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SBFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sbfm_pkg.sv =====
package sbfm_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int COUNT_WIDTH = 16;
	localparam int LEN_W       = $clog2(FRAME_BYTES);
	localparam int ADDR_W      = LEN_W + 1;

	localparam int CMD_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int FLEN_W      = 6;
	localparam int STAT_CNT_W  = 16;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 6;

	localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_IDLE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ERROR = 3'd4;

	localparam logic [MODE_W-1:0] MODE_EOL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEN  = 2'd1;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic take;
		logic fetch;
		logic emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic read_go;
		logic rd_last;
		logic out_free;
	} ctl_stat_t;

endpackage

// ===== rtl/sbfm_req_if.sv =====
interface sbfm_req_if import sbfm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink (input valid, input command, input data_byte, output ready);
endinterface

// ===== rtl/sbfm_rsp_if.sv =====
interface sbfm_rsp_if import sbfm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [BYTE_W-1:0]     out_byte;
	logic                  out_valid;
	logic                  out_last;
	logic                  frame_ready;
	logic [FLEN_W-1:0]     frame_length;
	logic [STAT_CNT_W-1:0] drop_total;
	logic [STAT_CNT_W-1:0] ovf_total;
	logic [STAT_CNT_W-1:0] frame_total;

	modport source (
		output valid, output out_byte, output out_valid, output out_last,
		output frame_ready, output frame_length, output drop_total,
		output ovf_total, output frame_total, input ready
	);
	modport sink (
		input valid, input out_byte, input out_valid, input out_last,
		input frame_ready, input frame_length, input drop_total,
		input ovf_total, input frame_total, output ready
	);
endinterface

// ===== rtl/sbfm_ctrl.sv =====
module sbfm_ctrl import sbfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign req_ready = (state_q == ST_IDLE) && stat.out_free;
	assign cmd.take  = req_valid && req_ready;
	assign cmd.fetch = (state_q == ST_FETCH);
	assign cmd.emit  = (state_q == ST_EMIT) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take && stat.read_go) state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.emit) state_q <= stat.rd_last ? ST_IDLE : ST_FETCH;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sbfm_datapath.sv =====
module sbfm_datapath import sbfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output ctl_stat_t             stat,
	input  logic [CMD_W-1:0]      command,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sbfm_rsp_if.source            rsp
);

`include "scanner_byte_framer_mailbox_macros.svh"

	logic [BYTE_W-1:0] mem [0:2**ADDR_W-1];

	logic [MODE_W-1:0]      mode_q, nxt_mode;
	logic [FLEN_W-1:0]      fixed_q, nxt_fixed;
	logic [LEN_W-1:0]       asm_len_q, nxt_asm_len;
	logic [LEN_W-1:0]       mbox_len_q, nxt_mbox_len;
	logic                   mbox_full_q, nxt_mbox_full;
	logic                   work_bank_q, nxt_work_bank;
	logic                   mail_bank_q, nxt_mail_bank;
	logic [COUNT_WIDTH-1:0] drop_q, nxt_drop;
	logic [COUNT_WIDTH-1:0] ovf_q, nxt_ovf;
	logic [COUNT_WIDTH-1:0] pub_q, nxt_pub;
	logic [LEN_W-1:0]       rd_idx_q, rd_len_q;
	logic                   rd_bank_q;
	logic [BYTE_W-1:0]      rd_data_q;

	logic                   out_vld_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_valid_q, out_last_q, out_ready_q;
	logic [LEN_W-1:0]       out_len_q;
	logic [COUNT_WIDTH-1:0] out_drop_q, out_ovf_q, out_pub_q;

	logic             is_eol, wr_en, pub, read_go, status_load;
	logic [LEN_W-1:0] len_inc, pub_len;

	assign is_eol  = (data_byte == CH_CR) || (data_byte == CH_LF);
	assign len_inc = asm_len_q + 1'b1;
	assign read_go = (command == CMD_READ) && mbox_full_q && (mbox_len_q != '0);

	assign stat.read_go  = read_go;
	assign stat.rd_last  = ((rd_idx_q + 1'b1) == rd_len_q);
	assign stat.out_free = !out_vld_q || rsp.ready;

	assign status_load = cmd.take && !read_go;

	always_comb begin
		nxt_mode      = mode_q;
		nxt_fixed     = fixed_q;
		nxt_asm_len   = asm_len_q;
		nxt_mbox_len  = mbox_len_q;
		nxt_mbox_full = mbox_full_q;
		nxt_work_bank = work_bank_q;
		nxt_mail_bank = mail_bank_q;
		nxt_drop      = drop_q;
		nxt_ovf       = ovf_q;
		nxt_pub       = pub_q;
		wr_en         = 1'b0;
		pub           = 1'b0;
		pub_len       = asm_len_q;
		if (cmd.take) begin
			case (command)
				CMD_BYTE: begin
					if (mode_q == MODE_FIXED && asm_len_q == '0 && is_eol) begin
						// drop leading line ends
					end else if (mode_q == MODE_EOL && is_eol) begin
						pub = 1'b1;
					end else if (asm_len_q >= LEN_W'(FRAME_BYTES - 1)) begin
						nxt_ovf     = ovf_q + 1'b1;
						nxt_asm_len = '0;
					end else begin
						wr_en       = 1'b1;
						nxt_asm_len = len_inc;
						if (mode_q == MODE_FIXED && fixed_q != '0 &&
							7'(len_inc) >= 7'(fixed_q)) begin
							pub     = 1'b1;
							pub_len = len_inc;
						end
					end
				end
				CMD_IDLE: begin
					if (mode_q == MODE_IDLE) pub = 1'b1;
				end
				CMD_READ, CMD_CLEAR: begin
					nxt_mbox_full = 1'b0;
					nxt_mbox_len  = '0;
				end
				CMD_ERROR: begin
					nxt_asm_len = '0;
				end
				default: begin
				end
			endcase
			if (pub && pub_len != '0) begin
				nxt_asm_len = '0;
				if (mbox_full_q) begin
					nxt_drop = drop_q + 1'b1;
				end else begin
					nxt_mbox_len  = pub_len;
					nxt_mbox_full = 1'b1;
					nxt_mail_bank = work_bank_q;
					nxt_work_bank = !work_bank_q;
					nxt_pub       = pub_q + 1'b1;
				end
			end
		end
		if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_MODE: begin
					if (cfg_data[MODE_W-1:0] != MODE_RSVD) nxt_mode = cfg_data[MODE_W-1:0];
					nxt_asm_len = '0;
				end
				REG_FIXED_LEN: begin
					nxt_fixed   = cfg_data[FLEN_W-1:0];
					nxt_asm_len = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[{work_bank_q, asm_len_q}] <= data_byte;
		if (cmd.fetch) rd_data_q <= mem[{rd_bank_q, rd_idx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_EOL;
			fixed_q     <= '0;
			asm_len_q   <= '0;
			mbox_len_q  <= '0;
			mbox_full_q <= 1'b0;
			work_bank_q <= 1'b0;
			mail_bank_q <= 1'b1;
			drop_q      <= '0;
			ovf_q       <= '0;
			pub_q       <= '0;
			rd_idx_q    <= '0;
			rd_len_q    <= '0;
			rd_bank_q   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			mode_q      <= nxt_mode;
			fixed_q     <= nxt_fixed;
			asm_len_q   <= nxt_asm_len;
			mbox_len_q  <= nxt_mbox_len;
			mbox_full_q <= nxt_mbox_full;
			work_bank_q <= nxt_work_bank;
			mail_bank_q <= nxt_mail_bank;
			drop_q      <= nxt_drop;
			ovf_q       <= nxt_ovf;
			pub_q       <= nxt_pub;
			if (cmd.take && read_go) begin
				rd_idx_q  <= '0;
				rd_len_q  <= mbox_len_q;
				rd_bank_q <= mail_bank_q;
			end else if (cmd.emit) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (status_load || cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status_load) begin
			out_byte_q  <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b1;
			out_ready_q <= nxt_mbox_full;
			out_len_q   <= nxt_mbox_len;
			out_drop_q  <= nxt_drop;
			out_ovf_q   <= nxt_ovf;
			out_pub_q   <= nxt_pub;
		end else if (cmd.emit) begin
			out_byte_q  <= rd_data_q;
			out_valid_q <= 1'b1;
			out_last_q  <= stat.rd_last;
			out_ready_q <= mbox_full_q;
			out_len_q   <= mbox_len_q;
			out_drop_q  <= drop_q;
			out_ovf_q   <= ovf_q;
			out_pub_q   <= pub_q;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.out_byte     = out_byte_q;
	assign rsp.out_valid    = out_valid_q;
	assign rsp.out_last     = out_last_q;
	assign rsp.frame_ready  = out_ready_q;
	assign rsp.frame_length = FLEN_W'(out_len_q);
	assign rsp.drop_total   = STAT_CNT_W'(out_drop_q);
	assign rsp.ovf_total    = STAT_CNT_W'(out_ovf_q);
	assign rsp.frame_total  = STAT_CNT_W'(out_pub_q);

	`SBFM_ASSERT_IMPL(a_full_has_len, clk, arst_n, mbox_full_q, mbox_len_q != '0, "full slot with zero length")
	`SBFM_ASSERT_IMPL(a_empty_no_len, clk, arst_n, !mbox_full_q, mbox_len_q == '0, "empty slot with nonzero length")
	`SBFM_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, !out_vld_q || rsp.ready, "byte loaded over a pending result")
	`SBFM_ASSERT_NEXT(a_read_empties, clk, arst_n, cmd.take && command == CMD_READ, !mbox_full_q, "read left the slot full")

endmodule

// ===== rtl/scanner_byte_framer_mailbox.sv =====
// Byte framer with a one-slot mailbox. Requests on req carry a command (received byte, line
// idle, read, clear, receive error) and a byte; each request yields one status result on rsp,
// except a read of a stored frame, which yields one result per stored byte. A read steps through
// the registered read port of the frame memory, with one fetch state and one emit state per byte;
// a new request is taken only when the controller is idle and the result register is free. Finished
// frames swap between two banks of that memory rather than being copied. The frame memory needs
// no clearing pass after reset. Write cfg_index 0 (frame mode) or 1 (fixed length) only while
// the block is idle; any such write clears the frame under assembly.
module scanner_byte_framer_mailbox import sbfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	sbfm_req_if.sink              req,
	sbfm_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;
	logic      ready;

	assign req.ready = ready;

	sbfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sbfm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.command   (req.command),
		.data_byte (req.data_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule

// ===== bench/scanner_byte_framer_mailbox_tb.sv =====
module scanner_byte_framer_mailbox_tb;
	import sbfm_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int SETTLE_HOLD     = 4;
	localparam int TAIL_CYCLES     = 2 * FRAME_BYTES + 8;

	typedef struct packed {
		logic [BYTE_W-1:0]     out_byte;
		logic                  out_valid;
		logic                  out_last;
		logic                  frame_ready;
		logic [FLEN_W-1:0]     frame_length;
		logic [STAT_CNT_W-1:0] drop_total;
		logic [STAT_CNT_W-1:0] ovf_total;
		logic [STAT_CNT_W-1:0] frame_total;
	} framer_status_t;

	class framer_scoreboard;
		logic [MODE_W-1:0]     cur_mode;
		logic [FLEN_W-1:0]     fixed_len;
		logic [BYTE_W-1:0]     asm_buf [FRAME_BYTES];
		int                    asm_len;
		logic [BYTE_W-1:0]     box_buf [FRAME_BYTES];
		int                    box_len;
		bit                    box_full;
		logic [STAT_CNT_W-1:0] drops;
		logic [STAT_CNT_W-1:0] overflows;
		logic [STAT_CNT_W-1:0] publishes;
		framer_status_t        status_q[$];
		int                    errors;

		function new();
			cur_mode  = MODE_EOL;
			fixed_len = '0;
			asm_len   = 0;
			box_len   = 0;
			box_full  = 1'b0;
			drops     = '0;
			overflows = '0;
			publishes = '0;
			errors    = 0;
		endfunction

		function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FRAME_MODE) begin
				if (data[MODE_W-1:0] != MODE_RSVD)
					cur_mode = data[MODE_W-1:0];
				asm_len = 0;
			end else if (idx == REG_FIXED_LEN) begin
				fixed_len = data[FLEN_W-1:0];
				asm_len   = 0;
			end
		endfunction

		function void push_status(logic [BYTE_W-1:0] b, bit v, bit last);
			framer_status_t s;
			s.out_byte     = b;
			s.out_valid    = v;
			s.out_last     = last;
			s.frame_ready  = box_full;
			s.frame_length = FLEN_W'(box_len);
			s.drop_total   = drops;
			s.ovf_total    = overflows;
			s.frame_total  = publishes;
			status_q.push_back(s);
		endfunction

		function void publish();
			if (asm_len == 0)
				return;
			if (box_full) begin
				drops++;
				asm_len = 0;
				return;
			end
			for (int i = 0; i < asm_len; i++)
				box_buf[i] = asm_buf[i];
			box_len  = asm_len;
			box_full = 1'b1;
			publishes++;
			asm_len = 0;
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b);
			bit eol;
			eol = (b == CH_CR) || (b == CH_LF);
			if (cur_mode == MODE_FIXED && asm_len == 0 && eol)
				return;
			if (cur_mode == MODE_EOL && eol) begin
				publish();
				return;
			end
			if (asm_len >= FRAME_BYTES - 1) begin
				overflows++;
				asm_len = 0;
				return;
			end
			asm_buf[asm_len] = b;
			asm_len++;
			if (cur_mode == MODE_FIXED && fixed_len != 0 && asm_len >= int'(fixed_len))
				publish();
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
			int n;
			if (cmd == CMD_READ) begin
				if (!box_full || box_len == 0) begin
					box_full = 1'b0;
					box_len  = 0;
					push_status('0, 1'b0, 1'b1);
				end else begin
					n        = box_len;
					box_full = 1'b0;
					box_len  = 0;
					for (int i = 0; i < n; i++)
						push_status(box_buf[i], 1'b1, i == n - 1);
				end
			end else begin
				case (cmd)
					CMD_BYTE: take_byte(b);
					CMD_IDLE: begin
						if (cur_mode == MODE_IDLE)
							publish();
					end
					CMD_CLEAR: begin
						box_full = 1'b0;
						box_len  = 0;
					end
					CMD_ERROR: asm_len = 0;
					default: ;
				endcase
				push_status('0, 1'b0, 1'b1);
			end
		endfunction

		function void report(string name, logic [STAT_CNT_W-1:0] want, logic [STAT_CNT_W-1:0] got);
			$display("%0t rsp %s mismatch: expected %0h actual %0h", $time, name, want, got);
			errors++;
		endfunction

		function void check_status(framer_status_t got);
			framer_status_t want;
			if (status_q.size() == 0) begin
				$display("%0t unexpected rsp: expected none, actual byte %0h valid %0b last %0b",
					$time, got.out_byte, got.out_valid, got.out_last);
				errors++;
				return;
			end
			want = status_q.pop_front();
			if (got.out_byte !== want.out_byte)
				report("out_byte", STAT_CNT_W'(want.out_byte), STAT_CNT_W'(got.out_byte));
			if (got.out_valid !== want.out_valid)
				report("out_valid", STAT_CNT_W'(want.out_valid), STAT_CNT_W'(got.out_valid));
			if (got.out_last !== want.out_last)
				report("out_last", STAT_CNT_W'(want.out_last), STAT_CNT_W'(got.out_last));
			if (got.frame_ready !== want.frame_ready)
				report("frame_ready", STAT_CNT_W'(want.frame_ready),
					STAT_CNT_W'(got.frame_ready));
			if (got.frame_length !== want.frame_length)
				report("frame_length", STAT_CNT_W'(want.frame_length),
					STAT_CNT_W'(got.frame_length));
			if (got.drop_total !== want.drop_total)
				report("drop_total", want.drop_total, got.drop_total);
			if (got.ovf_total !== want.ovf_total)
				report("ovf_total", want.ovf_total, got.ovf_total);
			if (got.frame_total !== want.frame_total)
				report("frame_total", want.frame_total, got.frame_total);
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sbfm_req_if req_ch ();
	sbfm_rsp_if rsp_ch ();

	scanner_byte_framer_mailbox u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	framer_scoreboard sb;
	int               sent;
	int               req_burst;
	int               rsp_burst;
	int               quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			burst = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		b = 8'($urandom);
		while (b == CH_CR || b == CH_LF)
			b = 8'($urandom);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] eol_byte();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	task automatic send(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
		int gap;
		gap = draw_gap(req_burst);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.command   <= cmd;
		req_ch.data_byte <= b;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, b);
		sent++;
	endtask

	// hold requests until every result is back and the block has gone quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE_HOLD) @(posedge clk);
	endtask

	task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.apply_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame();
		int len;
		logic [BYTE_W-1:0] b;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
		if (sb.cur_mode == MODE_FIXED) begin
			if (sb.fixed_len != 0 && sb.fixed_len <= 20)
				len = int'(sb.fixed_len) - sb.asm_len;
			if (len < 1)
				len = 1;
			if ($urandom_range(0, 2) == 0)
				send(CMD_BYTE, eol_byte());
		end
		for (int i = 0; i < len; i++) begin
			b = (sb.cur_mode == MODE_EOL) ? plain_byte() : 8'($urandom);
			send(CMD_BYTE, b);
		end
		case (sb.cur_mode)
			MODE_EOL: send(CMD_BYTE, eol_byte());
			MODE_IDLE: send(CMD_IDLE, 8'($urandom));
			default: ;
		endcase
		if ($urandom_range(0, 3) != 0)
			send(CMD_READ, 8'($urandom));
	endtask

	task automatic run_phase(int budget);
		int stop;
		int kind;
		stop = sent + budget;
		while (sent < stop) begin
			kind = $urandom_range(0, 9);
			case (kind)
				6: begin
					repeat ($urandom_range(1, 3))
						send(3'($urandom_range(0, 7)), 8'($urandom));
				end
				7: begin
					repeat ($urandom_range(1, 4))
						send(CMD_BYTE, plain_byte());
					send($urandom_range(0, 1) ? CMD_ERROR : CMD_CLEAR, 8'($urandom));
				end
				8: send($urandom_range(0, 1) ? CMD_CLEAR : CMD_READ, 8'($urandom));
				9: settle();
				default: send_frame();
			endcase
		end
	endtask

	task automatic send_plain_run(int count);
		repeat (count)
			send(CMD_BYTE, plain_byte());
	endtask

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t watchdog: no handshake for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, sb.pending());
			$display("status: fail");
			$finish;
		end
	end

	initial begin : rsp_side
		int stall;
		framer_status_t got;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_gap(rsp_burst);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.out_byte     = rsp_ch.out_byte;
			got.out_valid    = rsp_ch.out_valid;
			got.out_last     = rsp_ch.out_last;
			got.frame_ready  = rsp_ch.frame_ready;
			got.frame_length = rsp_ch.frame_length;
			got.drop_total   = rsp_ch.drop_total;
			got.ovf_total    = rsp_ch.ovf_total;
			got.frame_total  = rsp_ch.frame_total;
			sb.check_status(got);
		end
	end

	initial begin
		sb               = new();
		sent             = 0;
		req_burst        = 0;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_FRAME_MODE;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.command   <= CMD_BYTE;
		req_ch.data_byte <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(CMD_READ, 8'h00);
		send(CMD_BYTE, 8'h00);
		send(CMD_BYTE, 8'hFF);
		send(CMD_BYTE, 8'h41);
		send(CMD_BYTE, CH_CR);
		// mailbox still full: drop
		send(CMD_BYTE, 8'h42);
		send(CMD_BYTE, CH_LF);
		send(CMD_IDLE, 8'hFF);
		send(CMD_RSVD5, 8'h55);
		send(CMD_RSVD6, 8'hAA);
		send(CMD_RSVD7, 8'hFF);
		send(CMD_READ, 8'hFF);
		send(CMD_BYTE, CH_CR);
		send(CMD_BYTE, 8'h43);
		send(CMD_BYTE, CH_LF);
		send(CMD_CLEAR, 8'h00);
		send(CMD_READ, 8'h00);
		send(CMD_BYTE, 8'h44);
		send(CMD_ERROR, 8'h00);
		send(CMD_BYTE, CH_CR);
		send(CMD_READ, 8'h00);
		// register write drops the partial frame
		send(CMD_BYTE, 8'h45);
		settle();
		program_register(REG_FRAME_MODE, {4'hF, MODE_IDLE});
		send(CMD_IDLE, 8'h00);
		send(CMD_READ, 8'h00);
		settle();
		program_register(REG_FIXED_LEN, 6'd2);
		program_register(REG_FRAME_MODE, {4'h0, MODE_FIXED});
		send(CMD_BYTE, CH_LF);
		send(CMD_BYTE, CH_CR);
		send(CMD_BYTE, 8'h31);
		send(CMD_BYTE, CH_CR);
		send(CMD_READ, 8'h00);

		settle();
		program_register(REG_FRAME_MODE, {4'h0, MODE_EOL});
		program_register(REG_FIXED_LEN, 6'h3F);
		run_phase(5);

		settle();
		program_register(REG_FRAME_MODE, {4'hF, MODE_IDLE});
		send_plain_run(FRAME_BYTES);
		send(CMD_IDLE, 8'h00);
		run_phase(5);

		settle();
		program_register(REG_FIXED_LEN, 6'd1);
		program_register(REG_FRAME_MODE, {4'hA, MODE_FIXED});
		run_phase(5);

		settle();
		program_register(REG_FIXED_LEN, 6'd0);
		run_phase(5);

		settle();
		program_register(REG_FIXED_LEN, 6'd63);
		send_plain_run(FRAME_BYTES - 1);
		send(CMD_READ, 8'h00);
		run_phase(4);

		settle();
		program_register(REG_FIXED_LEN, 6'($urandom_range(2, 8)));
		run_phase(5);

		settle();
		program_register(REG_FRAME_MODE, {4'($urandom), MODE_RSVD});
		program_register(REG_SPARE2, 6'($urandom));
		program_register(REG_SPARE3, 6'($urandom));
		run_phase(5);

		settle();
		program_register(REG_FRAME_MODE, {4'h5, MODE_EOL});
		run_phase(6);

		req_ch.valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
